// ===== rtl/bma_pkg.sv =====
// ============================================================================
// bma_pkg
// Shared types, codes and helper functions for the Barrett modular ALU.
// ============================================================================
`timescale 1ns / 1ps

package bma_pkg;

  typedef enum logic [3:0] {
    MODE_MUL           = 4'd0,
    MODE_MUL_ADD       = 4'd1,
    MODE_MUL_SUB       = 4'd2,
    MODE_ADD           = 4'd3,
    MODE_SUB           = 4'd4,
    MODE_NEGATE        = 4'd5,
    MODE_REDUCE        = 4'd6,
    MODE_REDUCE_SIGNED = 4'd7,
    MODE_REDUCE_WIDE   = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODULUS     = 2'd0,
    REG_MU          = 2'd1,
    REG_SHIFT       = 2'd2,
    REG_WIDE_WEIGHT = 2'd3
  } reg_idx_e;

  localparam logic [31:0] ModulusReset    = 32'd2;
  localparam logic [63:0] MuReset         = 64'h8000_0000_0000_0000;
  localparam logic [4:0]  ShiftReset      = 5'd0;
  localparam logic [31:0] WideWeightReset = 32'd0;

  // Settings seen by each reduction pipe.
  typedef struct packed {
    logic [31:0] modulus;
    logic [63:0] mu;
    logic [4:0]  shift;
  } barrett_cfg_t;

  // Per-transaction information that rides along the reduction pipes.
  typedef struct packed {
    mode_e       mode;
    logic [31:0] acc;
    logic        neg;
    logic        last;
    logic [63:0] early;
  } side_t;

  // One conditional subtraction: the unsigned minimum of r and r - q.
  function automatic logic [63:0] fold_once(logic [63:0] r, logic [31:0] q);
    logic [63:0] t;
    t = r - {32'h0, q};
    return (t < r) ? t : r;
  endfunction

  // Adds q back when the difference went negative.
  function automatic logic [63:0] sign_fix(logic [63:0] d, logic [31:0] q);
    return d[63] ? d + {32'h0, q} : d;
  endfunction

endpackage

// ===== rtl/bma_req_if.sv =====
// ============================================================================
// bma_req_if
// Request channel of the modular ALU: mode, operands, accumulator, last mark.
// ============================================================================
`timescale 1ns / 1ps

interface bma_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  logic [31:0] accumulator;
  logic        last_in;

  modport source (
    output valid, mode, operand_a, operand_b, accumulator, last_in,
    input  ready
  );

  modport sink (
    input  valid, mode, operand_a, operand_b, accumulator, last_in,
    output ready
  );
endinterface

// ===== rtl/bma_rsp_if.sv =====
// ============================================================================
// bma_rsp_if
// Response channel of the modular ALU: residue and last mark.
// ============================================================================
`timescale 1ns / 1ps

interface bma_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        last_out;

  modport source (
    output valid, result, last_out,
    input  ready
  );

  modport sink (
    input  valid, result, last_out,
    output ready
  );
endinterface

// ===== rtl/bma_barrett.sv =====
// ============================================================================
// bma_barrett
// Seven-stage Barrett reduction pipe: shift, approximate high product with
// mu, estimate times q, subtract, then two conditional subtractions.
// ============================================================================
`timescale 1ns / 1ps

module bma_barrett (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  bma_pkg::barrett_cfg_t cfg_i,
  input  logic                  valid_i,
  input  logic [63:0]           value_i,
  input  bma_pkg::side_t        side_i,
  output logic                  valid_o,
  output logic [63:0]           value_o,
  output bma_pkg::side_t        side_o
);

  logic [6:0] valid_q;

  // Stage 0: shifted value.
  logic [63:0]    s0_v_q, s0_s_q;
  bma_pkg::side_t s0_side_q;
  // Stage 1: three partial products of the high-product estimate.
  logic [63:0]    s1_v_q, s1_lh_q, s1_hl_q, s1_hh_q;
  bma_pkg::side_t s1_side_q;
  // Stage 2: quotient estimate.
  logic [63:0]    s2_v_q, s2_est_q;
  bma_pkg::side_t s2_side_q;
  // Stage 3: estimate times q.
  logic [63:0]    s3_v_q, s3_pl_q;
  logic [31:0]    s3_ph_q;
  bma_pkg::side_t s3_side_q;
  // Stage 4: raw remainder; stages 5 and 6: corrections.
  logic [63:0]    s4_r_q, s5_r_q, s6_r_q;
  bma_pkg::side_t s4_side_q, s5_side_q, s6_side_q;

  logic [63:0] lh_d, hl_d, hh_d, mid_d, est_d, pl_d;
  logic [31:0] ph_d;

  always_comb begin
    lh_d  = s0_s_q[31:0] * cfg_i.mu[63:32];
    hl_d  = s0_s_q[63:32] * cfg_i.mu[31:0];
    hh_d  = s0_s_q[63:32] * cfg_i.mu[63:32];
    // The low-by-low partial product is left out on purpose.
    mid_d = s1_hl_q + {32'h0, s1_lh_q[31:0]};
    est_d = s1_hh_q + {32'h0, s1_lh_q[63:32]} + {32'h0, mid_d[63:32]};
    pl_d  = s2_est_q[31:0] * cfg_i.modulus;
    ph_d  = s2_est_q[63:32] * cfg_i.modulus;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_v_q    <= value_i;
      s0_s_q    <= value_i >> cfg_i.shift;
      s0_side_q <= side_i;

      s1_v_q    <= s0_v_q;
      s1_lh_q   <= lh_d;
      s1_hl_q   <= hl_d;
      s1_hh_q   <= hh_d;
      s1_side_q <= s0_side_q;

      s2_v_q    <= s1_v_q;
      s2_est_q  <= est_d;
      s2_side_q <= s1_side_q;

      s3_v_q    <= s2_v_q;
      s3_pl_q   <= pl_d;
      s3_ph_q   <= ph_d;
      s3_side_q <= s2_side_q;

      s4_r_q    <= s3_v_q - s3_pl_q - {s3_ph_q, 32'h0};
      s4_side_q <= s3_side_q;

      s5_r_q    <= bma_pkg::fold_once(s4_r_q, cfg_i.modulus);
      s5_side_q <= s4_side_q;

      s6_r_q    <= bma_pkg::fold_once(s5_r_q, cfg_i.modulus);
      s6_side_q <= s5_side_q;
    end
  end

  assign valid_o = valid_q[6];
  assign value_o = s6_r_q;
  assign side_o  = s6_side_q;

endmodule

// ===== rtl/barrett_modular_alu_unit.sv =====
// ============================================================================
// barrett_modular_alu_unit
// Every mode takes the same path from the accepting edge to the output register:
// two operand stages, the first seven-stage Barrett pipe, two stages for the
// two-word reduce, the second Barrett pipe and two finishing stages.
// Throughput: one transaction per cycle while the output is not stalled.
// A stalled output freezes the whole pipe.
// Reset clears all valid bits and loads the registers with their reset values.
// ============================================================================
`timescale 1ns / 1ps

module barrett_modular_alu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  bma_req_if.sink     req_i,
  bma_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------- registers
  logic [31:0] modulus_q, wide_weight_q;
  logic [63:0] mu_q;
  logic [4:0]  shift_q;
  bma_pkg::reg_idx_e  reg_idx;
  bma_pkg::barrett_cfg_t bcfg;

  assign reg_idx = bma_pkg::reg_idx_e'(paddr[4:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q     <= bma_pkg::ModulusReset;
      mu_q          <= bma_pkg::MuReset;
      shift_q       <= bma_pkg::ShiftReset;
      wide_weight_q <= bma_pkg::WideWeightReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        bma_pkg::REG_MODULUS:     modulus_q     <= pwdata[31:0];
        bma_pkg::REG_MU:          mu_q          <= pwdata;
        bma_pkg::REG_SHIFT:       shift_q       <= pwdata[4:0];
        bma_pkg::REG_WIDE_WEIGHT: wide_weight_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bma_pkg::REG_MODULUS:     prdata = {32'h0, modulus_q};
      bma_pkg::REG_MU:          prdata = mu_q;
      bma_pkg::REG_SHIFT:       prdata = {59'h0, shift_q};
      bma_pkg::REG_WIDE_WEIGHT: prdata = {32'h0, wide_weight_q};
      default:                  prdata = '0;
    endcase
  end

  assign bcfg = '{modulus: modulus_q, mu: mu_q, shift: shift_q};

  // ---------------------------------------------------------- pipe control
  logic en;
  logic rsp_valid_q;

  assign en          = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  // ------------------------------------------------------ P1: operand prep
  bma_pkg::mode_e in_mode;
  logic [63:0] in_a, in_b;
  logic [63:0] pp0_d;
  logic [31:0] pp1_d, pp2_d;

  logic           p1_valid_q;
  bma_pkg::mode_e p1_mode_q;
  logic [63:0]    p1_pp0_q, p1_direct_q, p1_b_q, p1_sum_q, p1_diff_q, p1_negq_q;
  logic [31:0]    p1_pp1_q, p1_pp2_q, p1_acc_q;
  logic           p1_neg_q, p1_zero_q, p1_last_q;

  always_comb begin
    in_mode = bma_pkg::mode_e'(req_i.mode);
    in_a    = req_i.operand_a;
    in_b    = req_i.operand_b;
    pp0_d   = in_a[31:0] * in_b[31:0];
    pp1_d   = in_a[31:0] * in_b[63:32];
    pp2_d   = in_a[63:32] * in_b[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_mode_q   <= in_mode;
      p1_pp0_q    <= pp0_d;
      p1_pp1_q    <= pp1_d;
      p1_pp2_q    <= pp2_d;
      // Signed reduce works on the magnitude of a negative operand.
      p1_direct_q <= (in_mode == bma_pkg::MODE_REDUCE_SIGNED && in_a[63]) ? (64'h0 - in_a)
                                                                           : in_a;
      p1_b_q      <= in_b;
      p1_sum_q    <= in_a + in_b;
      p1_diff_q   <= in_a - in_b;
      p1_negq_q   <= {32'h0, modulus_q} - in_a;
      p1_zero_q   <= (in_a == 64'h0);
      p1_neg_q    <= in_a[63];
      p1_acc_q    <= req_i.accumulator;
      p1_last_q   <= req_i.last_in;
    end
  end

  // ---------------------------------------- P2: product and early results
  logic [31:0]    cross_d;
  logic [63:0]    v1_d;
  bma_pkg::side_t side1_d;

  logic           p2_valid_q;
  logic [63:0]    p2_v_q;
  bma_pkg::side_t p2_side_q;

  always_comb begin
    cross_d = p1_pp1_q + p1_pp2_q;
    if (p1_mode_q inside {bma_pkg::MODE_MUL, bma_pkg::MODE_MUL_ADD, bma_pkg::MODE_MUL_SUB}) begin
      v1_d = p1_pp0_q + {cross_d, 32'h0};
    end else begin
      v1_d = p1_direct_q;
    end
    side1_d.mode = p1_mode_q;
    side1_d.acc  = p1_acc_q;
    side1_d.neg  = p1_neg_q;
    side1_d.last = p1_last_q;
    // Add, subtract and negate finish here; the two-word reduce parks its
    // low word in the same slot until the second reduction.
    case (p1_mode_q)
      bma_pkg::MODE_ADD:         side1_d.early = bma_pkg::fold_once(p1_sum_q, modulus_q);
      bma_pkg::MODE_SUB:         side1_d.early = bma_pkg::sign_fix(p1_diff_q, modulus_q);
      bma_pkg::MODE_NEGATE:      side1_d.early = p1_zero_q ? 64'h0 : p1_negq_q;
      bma_pkg::MODE_REDUCE_WIDE: side1_d.early = p1_b_q;
      default:                   side1_d.early = 64'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_v_q    <= v1_d;
      p2_side_q <= side1_d;
    end
  end

  // ------------------------------------------------------ first reduction
  logic           r1_valid;
  logic [63:0]    r1_value;
  bma_pkg::side_t r1_side;

  bma_barrett u_reduce_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (bcfg),
    .valid_i (p2_valid_q),
    .value_i (p2_v_q),
    .side_i  (p2_side_q),
    .valid_o (r1_valid),
    .value_o (r1_value),
    .side_o  (r1_side)
  );

  // ------------------------------------- P3: high word times 2^64 mod q
  logic [63:0]    m0_d;
  logic [31:0]    m1_d;

  logic           p3_valid_q;
  logic [63:0]    p3_r1_q, p3_m0_q;
  logic [31:0]    p3_m1_q;
  bma_pkg::side_t p3_side_q;

  always_comb begin
    m0_d = r1_value[31:0] * wide_weight_q;
    m1_d = r1_value[63:32] * wide_weight_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else if (en) begin
      p3_valid_q <= r1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_r1_q   <= r1_value;
      p3_m0_q   <= m0_d;
      p3_m1_q   <= m1_d;
      p3_side_q <= r1_side;
    end
  end

  // ------------------------------------------- P4: second reduction input
  logic [63:0]    v2_d;
  bma_pkg::side_t side2_d;

  logic           p4_valid_q;
  logic [63:0]    p4_v_q;
  bma_pkg::side_t p4_side_q;

  always_comb begin
    v2_d    = p3_m0_q + {p3_m1_q, 32'h0} + p3_side_q.early;
    side2_d = p3_side_q;
    // Single-reduction modes carry their residue past the second pipe.
    if (p3_side_q.mode inside {bma_pkg::MODE_MUL, bma_pkg::MODE_MUL_ADD,
                               bma_pkg::MODE_MUL_SUB, bma_pkg::MODE_REDUCE,
                               bma_pkg::MODE_REDUCE_SIGNED}) begin
      side2_d.early = p3_r1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_valid_q <= 1'b0;
    end else if (en) begin
      p4_valid_q <= p3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_v_q    <= v2_d;
      p4_side_q <= side2_d;
    end
  end

  // ----------------------------------------------------- second reduction
  logic           r2_valid;
  logic [63:0]    r2_value;
  bma_pkg::side_t r2_side;

  bma_barrett u_reduce_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (bcfg),
    .valid_i (p4_valid_q),
    .value_i (p4_v_q),
    .side_i  (p4_side_q),
    .valid_o (r2_valid),
    .value_o (r2_value),
    .side_o  (r2_side)
  );

  // ----------------------------------------------- P5: finishing operands
  logic [63:0]    x_d;

  logic           p5_valid_q;
  logic [63:0]    p5_x_q, p5_add_q, p5_sub_q, p5_negr_q;
  bma_pkg::mode_e p5_mode_q;
  logic           p5_neg_q, p5_last_q;

  assign x_d = (r2_side.mode == bma_pkg::MODE_REDUCE_WIDE) ? r2_value : r2_side.early;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_valid_q <= 1'b0;
    end else if (en) begin
      p5_valid_q <= r2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_x_q    <= x_d;
      p5_add_q  <= {32'h0, r2_side.acc} + x_d;
      p5_sub_q  <= {32'h0, r2_side.acc} - x_d;
      p5_negr_q <= {32'h0, modulus_q} - x_d;
      p5_mode_q <= r2_side.mode;
      p5_neg_q  <= r2_side.neg;
      p5_last_q <= r2_side.last;
    end
  end

  // ------------------------------------------ P6: select, output register
  logic [63:0] result_d;
  logic [63:0] rsp_result_q;
  logic        rsp_last_q;

  always_comb begin
    case (p5_mode_q) inside
      bma_pkg::MODE_MUL, bma_pkg::MODE_REDUCE, bma_pkg::MODE_ADD, bma_pkg::MODE_SUB,
      bma_pkg::MODE_NEGATE, bma_pkg::MODE_REDUCE_WIDE: result_d = p5_x_q;
      bma_pkg::MODE_MUL_ADD: result_d = bma_pkg::fold_once(p5_add_q, modulus_q);
      bma_pkg::MODE_MUL_SUB: result_d = bma_pkg::sign_fix(p5_sub_q, modulus_q);
      // A nonzero residue of a negative value maps to q minus that residue.
      bma_pkg::MODE_REDUCE_SIGNED: result_d = (p5_neg_q && p5_x_q != 64'h0) ? p5_negr_q
                                                                             : p5_x_q;
      default: result_d = 64'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      rsp_valid_q <= p5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_result_q <= result_d;
      rsp_last_q   <= p5_last_q;
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.result   = rsp_result_q;
  assign rsp_o.last_out = rsp_last_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Barrett modular ALU testbench
// Walks a short table of directed transactions at the reset settings, then
// programs a series of moduli and Barrett constants (correct ones, extremes
// and deliberately odd ones) and streams random transactions through each.
// Every response is checked against an in-bench residue predictor or the table's
// expected value, while the request side idles in bursts outside the gapless
// phases and the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [63:0] AllOnes      = '1;
  localparam logic [63:0] SignBit      = 64'h8000_0000_0000_0000;
  localparam logic [3:0]  ModeUnusedLo = 4'd9;
  localparam logic [3:0]  ModeUnusedHi = 4'd15;
  localparam int          HoldOffCycles = 160;
  localparam int          MaxReports    = 10;

  typedef struct {
    logic [3:0]  mode;
    logic [63:0] a;
    logic [63:0] b;
    logic [31:0] acc;
    logic        last;
    bit          known;
    logic [63:0] want;
  } stim_t;

  typedef struct {
    logic [63:0] residue;
    logic        last;
  } residue_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  bma_req_if req_bus ();
  bma_rsp_if rsp_bus ();

  barrett_modular_alu_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the register file.
  logic [31:0] cfg_q;
  logic [63:0] cfg_mu;
  logic [4:0]  cfg_shift;
  logic [31:0] cfg_weight;

  residue_t pending_residues[$];
  int       mismatches;
  int       results_seen;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1ms;
    $display("barrett_modular_alu_unit regression: fail");
    $finish;
  end

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // ---------------- residue predictor ----------------

  // High word of x*y without the low-by-low 32x32 partial product.
  function automatic logic [63:0] truncated_high(logic [63:0] x, logic [63:0] y);
    logic [63:0] lh, hl, hh, mid;
    lh  = {32'h0, x[31:0]} * {32'h0, y[63:32]};
    hl  = {32'h0, x[63:32]} * {32'h0, y[31:0]};
    hh  = {32'h0, x[63:32]} * {32'h0, y[63:32]};
    mid = hl + {32'h0, lh[31:0]};
    return hh + (lh >> 32) + (mid >> 32);
  endfunction

  function automatic logic [63:0] trim_once(logic [63:0] r);
    logic [63:0] less;
    less = r - {32'h0, cfg_q};
    return (less < r) ? less : r;
  endfunction

  function automatic logic [63:0] barrett_residue(logic [63:0] v);
    logic [63:0] est, r;
    est = truncated_high(v >> cfg_shift, cfg_mu);
    r   = v - est * {32'h0, cfg_q};
    return trim_once(trim_once(r));
  endfunction

  function automatic logic [63:0] lift_negative(logic [63:0] d);
    return d[63] ? d + {32'h0, cfg_q} : d;
  endfunction

  function automatic logic [63:0] predict_residue(stim_t s);
    logic [63:0] q64, mag, r, hi;
    q64 = {32'h0, cfg_q};
    r   = '0;
    case (s.mode)
      bma_pkg::MODE_MUL:     r = barrett_residue(s.a * s.b);
      bma_pkg::MODE_MUL_ADD: r = trim_once({32'h0, s.acc} + barrett_residue(s.a * s.b));
      bma_pkg::MODE_MUL_SUB: r = lift_negative({32'h0, s.acc} - barrett_residue(s.a * s.b));
      bma_pkg::MODE_ADD:     r = trim_once(s.a + s.b);
      bma_pkg::MODE_SUB:     r = lift_negative(s.a - s.b);
      bma_pkg::MODE_NEGATE:  r = (s.a == '0) ? '0 : q64 - s.a;
      bma_pkg::MODE_REDUCE:  r = barrett_residue(s.a);
      bma_pkg::MODE_REDUCE_SIGNED: begin
        mag = s.a[63] ? -s.a : s.a;
        r   = barrett_residue(mag);
        if (s.a[63] && r != '0) begin
          r = q64 - r;
        end
      end
      bma_pkg::MODE_REDUCE_WIDE: begin
        hi = barrett_residue(s.a);
        r  = barrett_residue(hi * {32'h0, cfg_weight} + s.b);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // ---------------- configuration port ----------------

  task automatic reg_write(bma_pkg::reg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      bma_pkg::REG_MODULUS:     cfg_q      = value[31:0];
      bma_pkg::REG_MU:          cfg_mu     = value;
      bma_pkg::REG_SHIFT:       cfg_shift  = value[4:0];
      bma_pkg::REG_WIDE_WEIGHT: cfg_weight = value[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(bma_pkg::reg_idx_e idx, logic [63:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      report($sformatf("register %s read", idx.name()), want, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_raw(logic [31:0] q, logic [63:0] mu, logic [4:0] shift,
                             logic [31:0] weight);
    reg_write(bma_pkg::REG_MODULUS, {32'h0, q});
    reg_write(bma_pkg::REG_MU, mu);
    reg_write(bma_pkg::REG_SHIFT, {59'h0, shift});
    reg_write(bma_pkg::REG_WIDE_WEIGHT, {32'h0, weight});
  endtask

  // Programs q with the constants that software would compute for it.
  task automatic program_modulus(logic [31:0] q);
    int           bits;
    logic [127:0] mu_wide, weight_wide;
    bits = 0;
    while ((q >> bits) != 0) bits++;
    mu_wide     = (128'd1 << (bits + 62)) / {96'h0, q};
    weight_wide = (128'd1 << 64) % {96'h0, q};
    program_raw(q, mu_wide[63:0], 5'(bits - 2), weight_wide[31:0]);
  endtask

  // ---------------- request side ----------------

  task automatic send_item(stim_t s);
    residue_t exp_res;
    @(negedge clk_i);
    req_bus.mode        <= s.mode;
    req_bus.operand_a   <= s.a;
    req_bus.operand_b   <= s.b;
    req_bus.accumulator <= s.acc;
    req_bus.last_in     <= s.last;
    req_bus.valid       <= 1'b1;
    do @(posedge clk_i); while (!req_bus.ready);
    exp_res.residue = s.known ? s.want : predict_residue(s);
    exp_res.last    = s.last;
    pending_residues.push_back(exp_res);
  endtask

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = {32'h0, cfg_q} - 64'd1;
      2: v = {$urandom, $urandom};
      3: v = AllOnes;
      4: v = {32'h0, cfg_q};
      default: v = (cfg_q > 32'd1) ? 64'($urandom_range(cfg_q - 32'd1, 0)) : 64'($urandom_range(1));
    endcase
    return v;
  endfunction

  function automatic stim_t random_item();
    stim_t s;
    int    pick;
    pick = $urandom_range(19);
    s.mode  = (pick < 18) ? 4'(pick / 2) : 4'($urandom_range(ModeUnusedHi, ModeUnusedLo));
    s.a     = pick_operand();
    s.b     = pick_operand();
    s.acc   = ($urandom_range(4) == 0) ? $urandom : s.b[31:0];
    if ($urandom_range(4) != 0 && cfg_q > 32'd1) begin
      s.acc = $urandom_range(cfg_q - 32'd1, 0);
    end
    s.last  = ($urandom_range(7) == 0);
    s.known = 1'b0;
    s.want  = '0;
    if (s.mode == bma_pkg::MODE_REDUCE_SIGNED && $urandom_range(1)) begin
      s.a = -s.a;
    end
    if (s.mode == bma_pkg::MODE_REDUCE_WIDE && $urandom_range(1)) begin
      s.a = {$urandom, $urandom};
      s.b = {$urandom, $urandom};
    end
    return s;
  endfunction

  task automatic run_phase(int count, bit gapless);
    int burst;
    burst = $urandom_range(24, 1);
    for (int i = 0; i < count; i++) begin
      send_item(random_item());
      burst--;
      if (burst == 0 && !gapless) begin
        @(negedge clk_i);
        req_bus.valid <= 1'b0;
        repeat ($urandom_range(5)) @(negedge clk_i);
        burst = $urandom_range(24, 1);
      end
    end
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_residues.size() != 0) @(posedge clk_i);
  endtask

  // ---------------- response side ----------------

  initial begin
    bit held_off;
    int kind, span;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && results_seen >= 200) begin
        // One long hold-off so the pipe freezes and the request side stalls.
        held_off = 1'b1;
        @(negedge clk_i);
        rsp_bus.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end
      kind = $urandom_range(2);
      span = (kind == 2) ? $urandom_range(8, 1) : $urandom_range(120, 20);
      repeat (span) begin
        @(negedge clk_i);
        case (kind)
          0: rsp_bus.ready <= 1'b1;
          1: rsp_bus.ready <= ($urandom_range(3) != 0);
          default: rsp_bus.ready <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    residue_t exp_res;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      results_seen++;
      if (pending_residues.size() == 0) begin
        report("unexpected transaction, residue", '0, rsp_bus.result);
      end else begin
        exp_res = pending_residues.pop_front();
        if (rsp_bus.result !== exp_res.residue) begin
          report("residue", exp_res.residue, rsp_bus.result);
        end
        if (rsp_bus.last_out !== exp_res.last) begin
          report("last_out", {63'h0, exp_res.last}, {63'h0, rsp_bus.last_out});
        end
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    stim_t directed[$];

    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_bus.valid       = 1'b0;
    req_bus.mode        = bma_pkg::MODE_MUL;
    req_bus.operand_a   = '0;
    req_bus.operand_b   = '0;
    req_bus.accumulator = '0;
    req_bus.last_in     = 1'b0;
    rsp_bus.ready       = 1'b0;
    mismatches          = 0;
    results_seen        = 0;
    cfg_q               = bma_pkg::ModulusReset;
    cfg_mu              = bma_pkg::MuReset;
    cfg_shift           = bma_pkg::ShiftReset;
    cfg_weight          = bma_pkg::WideWeightReset;

    // The directed rows run at the reset settings, where q is 2.
    directed = '{
      '{bma_pkg::MODE_MUL,           64'd0,   64'd0,   32'd0,        1'b0, 1'b1, 64'd0},
      '{bma_pkg::MODE_MUL,           AllOnes, AllOnes, 32'd0,        1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_MUL_ADD,       64'd3,   64'd5,   32'd1,        1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_MUL_ADD,       AllOnes, AllOnes, 32'hFFFFFFFF, 1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_MUL_SUB,       64'd7,   64'd9,   32'd0,        1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_MUL_SUB,       AllOnes, 64'd1,   32'hFFFFFFFF, 1'b1, 1'b0, 64'd0},
      '{bma_pkg::MODE_ADD,           64'd0,   64'd0,   32'd0,        1'b0, 1'b1, 64'd0},
      '{bma_pkg::MODE_ADD,           64'd1,   64'd1,   32'd0,        1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_ADD,           AllOnes, AllOnes, 32'd0,        1'b1, 1'b0, 64'd0},
      '{bma_pkg::MODE_SUB,           64'd0,   64'd0,   32'd0,        1'b0, 1'b1, 64'd0},
      '{bma_pkg::MODE_SUB,           64'd0,   64'd1,   32'd0,        1'b0, 1'b1, 64'd1},
      '{bma_pkg::MODE_SUB,           AllOnes, 64'd0,   32'd0,        1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_NEGATE,        64'd0,   64'd0,   32'd0,        1'b0, 1'b1, 64'd0},
      '{bma_pkg::MODE_NEGATE,        64'd1,   64'd0,   32'd0,        1'b0, 1'b1, 64'd1},
      '{bma_pkg::MODE_NEGATE,        AllOnes, AllOnes, 32'd0,        1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_REDUCE,        64'd0,   64'd0,   32'd0,        1'b0, 1'b1, 64'd0},
      '{bma_pkg::MODE_REDUCE,        AllOnes, 64'd0,   32'd0,        1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_REDUCE_SIGNED, AllOnes, 64'd0,   32'd0,        1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_REDUCE_SIGNED, SignBit, 64'd0,   32'd0,        1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_REDUCE_SIGNED, 64'd5,   64'd0,   32'd0,        1'b0, 1'b0, 64'd0},
      '{bma_pkg::MODE_REDUCE_WIDE,   64'd0,   64'd0,   32'd0,        1'b0, 1'b1, 64'd0},
      '{bma_pkg::MODE_REDUCE_WIDE,   AllOnes, AllOnes, 32'd0,        1'b0, 1'b0, 64'd0},
      '{ModeUnusedLo,                AllOnes, AllOnes, 32'hFFFFFFFF, 1'b1, 1'b1, 64'd0},
      '{ModeUnusedHi,                AllOnes, AllOnes, 32'hFFFFFFFF, 1'b1, 1'b1, 64'd0}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    reg_check(bma_pkg::REG_MODULUS, {32'h0, bma_pkg::ModulusReset});
    reg_check(bma_pkg::REG_MU, bma_pkg::MuReset);
    reg_check(bma_pkg::REG_SHIFT, {59'h0, bma_pkg::ShiftReset});
    reg_check(bma_pkg::REG_WIDE_WEIGHT, {32'h0, bma_pkg::WideWeightReset});

    foreach (directed[i]) send_item(directed[i]);
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    drain();

    program_modulus(32'd3);
    run_phase(150, 1'b0);
    drain();
    program_modulus(32'hFFFF_FFFF);
    run_phase(150, 1'b1);
    drain();
    program_modulus(32'h8000_0000);
    run_phase(150, 1'b0);
    drain();
    program_modulus(32'd65537);
    run_phase(150, 1'b0);
    drain();
    repeat (3) begin
      program_modulus($urandom_range(32'hFFFF_FFFF, 2));
      run_phase(150, $urandom_range(2) == 0);
      drain();
    end

    // Constants that do not match q: the datapath must still wrap exactly.
    program_raw($urandom_range(32'hFFFF_FFFF, 2), 64'd0, 5'd30, 32'hFFFF_FFFE);
    run_phase(100, 1'b0);
    drain();
    program_raw($urandom_range(32'hFFFF_FFFF, 2), AllOnes, 5'($urandom_range(30)), $urandom);
    run_phase(100, 1'b0);
    drain();
    program_modulus(32'd2);
    run_phase(50, 1'b0);
    drain();

    // Degenerate moduli run the same datapath.
    program_raw(32'd1, {$urandom, $urandom}, 5'd1, 32'd0);
    run_phase(25, 1'b0);
    drain();
    program_raw(32'd0, {$urandom, $urandom}, 5'($urandom_range(30)), $urandom);
    run_phase(25, 1'b0);
    drain();

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_residues.size() == 0) begin
      $display("barrett_modular_alu_unit regression: pass");
    end else begin
      $display("barrett_modular_alu_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bma_pkg.sv
rtl/bma_req_if.sv
rtl/bma_rsp_if.sv
rtl/bma_barrett.sv
rtl/barrett_modular_alu_unit.sv
tb/testbench.sv
